// ===== design/imudr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imudr_pkg
// Shared types, widths and saturation helpers for the dead-reckoning
// integrator.
// ----------------------------------------------------------------------------
package imudr_pkg;

  localparam int RAW_W       = 16;
  localparam int ELAPSED_W   = 16;
  localparam int SUM_W       = 48;
  localparam int POS_W       = 64;
  localparam int NUM_AXES    = 3;
  localparam int AXES_DEF    = 3;
  localparam int DT_BITS_DEF = 16;

  typedef struct packed {
    logic                        restart;
    logic [ELAPSED_W-1:0]        elapsed_ms;
    logic signed [RAW_W-1:0]     gyro_x;
    logic signed [RAW_W-1:0]     gyro_y;
    logic signed [RAW_W-1:0]     gyro_z;
    logic signed [RAW_W-1:0]     accel_x;
    logic signed [RAW_W-1:0]     accel_y;
    logic signed [RAW_W-1:0]     accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]     angle_x;
    logic signed [SUM_W-1:0]     angle_y;
    logic signed [SUM_W-1:0]     angle_z;
    logic signed [SUM_W-1:0]     vel_x;
    logic signed [SUM_W-1:0]     vel_y;
    logic signed [SUM_W-1:0]     vel_z;
    logic signed [POS_W-1:0]     pos_x;
    logic signed [POS_W-1:0]     pos_y;
    logic signed [POS_W-1:0]     pos_z;
  } result_t;

  // clamp a sum one bit wider back to the angle / velocity range
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/imudr_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imudr_axis
// One axis: angle, velocity and position sums with saturating update.
// ----------------------------------------------------------------------------
module imudr_axis #(
  parameter int DT_BITS = imudr_pkg::DT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic                                  restart,
  input  logic [DT_BITS-1:0]                    dt,
  input  logic signed [imudr_pkg::RAW_W-1:0]    gyro,
  input  logic signed [imudr_pkg::RAW_W-1:0]    accel,
  output logic signed [imudr_pkg::SUM_W-1:0]    angle,
  output logic signed [imudr_pkg::SUM_W-1:0]    vel,
  output logic signed [imudr_pkg::POS_W-1:0]    pos
);
  import imudr_pkg::*;

  localparam int RP_W = RAW_W + DT_BITS + 1;
  localparam int VP_W = SUM_W + DT_BITS + 1;

  logic signed [DT_BITS:0]   dts;
  logic signed [RP_W-1:0]    ang_prod;
  logic signed [RP_W-1:0]    acc_prod;
  logic signed [VP_W-1:0]    vel_prod;
  logic signed [SUM_W:0]     ang_wide;
  logic signed [SUM_W:0]     vel_wide;
  logic signed [POS_W:0]     pos_wide;
  logic signed [SUM_W-1:0]   angle_next;
  logic signed [SUM_W-1:0]   vel_next;
  logic signed [POS_W-1:0]   pos_next;

  assign dts      = $signed({1'b0, dt});
  assign ang_prod = gyro * dts;
  assign acc_prod = accel * dts;
  // position uses the velocity as it stood before this word
  assign vel_prod = vel * dts;

  assign ang_wide = (SUM_W+1)'(angle) + (SUM_W+1)'(ang_prod);
  assign vel_wide = (SUM_W+1)'(vel) + (SUM_W+1)'(acc_prod);
  assign pos_wide = (POS_W+1)'(pos) + (POS_W+1)'(vel_prod);

  assign angle_next = sat_sum(ang_wide);
  assign vel_next   = sat_sum(vel_wide);
  assign pos_next   = sat_pos(pos_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      vel   <= '0;
      pos   <= '0;
    end else if (step) begin
      if (restart) begin
        angle <= '0;
        vel   <= '0;
        pos   <= '0;
      end else begin
        angle <= angle_next;
        vel   <= vel_next;
        pos   <= pos_next;
      end
    end
  end

endmodule

// ===== design/imu_dead_reckoning_integrator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_dead_reckoning_integrator_unit
// Integrates gyro rate and acceleration over elapsed time into angle,
// velocity and position sums per axis, reporting all sums after each word.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_ready    sample_t
//   result    out        result_valid / result_ready    result_t
//
// one word per cycle sustained while results are taken; a word is held
// in the input register, and the sums update from it once the result
// side is free, and are shown from then on.
// the sum registers are the result register; they only move once the
// previous result is taken, so a stalled result holds and input backs up.
// synchronous reset clears every sum to zero and drops both valids.
// ----------------------------------------------------------------------------
module imu_dead_reckoning_integrator_unit #(
  parameter int AXES    = imudr_pkg::AXES_DEF,
  parameter int DT_BITS = imudr_pkg::DT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  imudr_pkg::sample_t  sample,
  output logic                result_valid,
  input  logic                result_ready,
  output imudr_pkg::result_t  result
);
  import imudr_pkg::*;

  logic                     hold_valid;
  sample_t                  hold;
  logic                     step;
  logic [DT_BITS-1:0]       dt;

  logic signed [RAW_W-1:0]  gyro_a  [NUM_AXES];
  logic signed [RAW_W-1:0]  accel_a [NUM_AXES];
  logic signed [SUM_W-1:0]  angle_a [NUM_AXES];
  logic signed [SUM_W-1:0]  vel_a   [NUM_AXES];
  logic signed [POS_W-1:0]  pos_a   [NUM_AXES];

  assign step         = hold_valid && (!result_valid || result_ready);
  assign sample_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (sample_ready) begin
        hold_valid <= sample_valid;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      hold <= sample;
    end
  end

  // elapsed time clamps to the dt width
  assign dt = (|(hold.elapsed_ms >> DT_BITS)) ? '1 : hold.elapsed_ms[DT_BITS-1:0];

  assign gyro_a[0]  = hold.gyro_x;
  assign gyro_a[1]  = hold.gyro_y;
  assign gyro_a[2]  = hold.gyro_z;
  assign accel_a[0] = hold.accel_x;
  assign accel_a[1] = hold.accel_y;
  assign accel_a[2] = hold.accel_z;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    if (i < AXES) begin : g_used
      imudr_axis #(
        .DT_BITS (DT_BITS)
      ) u_axis (
        .clk     (clk),
        .rst     (rst),
        .step    (step),
        .restart (hold.restart),
        .dt      (dt),
        .gyro    (gyro_a[i]),
        .accel   (accel_a[i]),
        .angle   (angle_a[i]),
        .vel     (vel_a[i]),
        .pos     (pos_a[i])
      );
    end else begin : g_unused
      assign angle_a[i] = '0;
      assign vel_a[i]   = '0;
      assign pos_a[i]   = '0;
    end
  end

  always_comb begin
    result.angle_x = angle_a[0];
    result.angle_y = angle_a[1];
    result.angle_z = angle_a[2];
    result.vel_x   = vel_a[0];
    result.vel_y   = vel_a[1];
    result.vel_z   = vel_a[2];
    result.pos_x   = pos_a[0];
    result.pos_y   = pos_a[1];
    result.pos_z   = pos_a[2];
  end

endmodule

// ===== design/imudr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imudr_checker
// Port-level checks on the integrator handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module imudr_checker (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_ready,
  input imudr_pkg::sample_t  sample,
  input logic                result_valid,
  input logic                result_ready,
  input imudr_pkg::result_t  result
);
  import imudr_pkg::*;

  // a stalled result keeps its word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("sample dropped or changed while stalled");

  // input only backs up behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid && !result_ready)
    else $error("sample not ready while result side free");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && sample_ready)
    else $error("valid state survived reset");

endmodule

bind imu_dead_reckoning_integrator_unit imudr_checker u_imudr_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample       (sample),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
